// File: rtl/ktl_pkg.sv
// Shared types, constants and decode functions for the keyword token lexer.
// Used by keyword_token_lexer_unit; depends on nothing else.

package ktl_pkg;

   localparam int POSITION_BITS = 16;
   localparam int LENGTH_BITS   = 8;
   localparam int KIND_BITS     = 5;
   localparam int FAULT_BITS    = 2;
   localparam int CHAR_BITS     = 8;
   localparam int WORD_CHARS    = 6;
   localparam int LETTERS_BITS  = WORD_CHARS * CHAR_BITS;
   localparam int KEYWORD_COUNT = 7;
   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_WORD,
      MODE_NUMBER,
      MODE_ERROR
   } scan_mode_type;

   typedef enum logic [FAULT_BITS-1:0] {
      FAULT_NONE       = 2'd0,
      FAULT_INVALID    = 2'd1,
      FAULT_FRACTIONAL = 2'd2
   } fault_type;

   localparam logic [KIND_BITS-1:0] KIND_LBRACE  = 5'd7;
   localparam logic [KIND_BITS-1:0] KIND_RBRACE  = 5'd8;
   localparam logic [KIND_BITS-1:0] KIND_LPAREN  = 5'd9;
   localparam logic [KIND_BITS-1:0] KIND_RPAREN  = 5'd10;
   localparam logic [KIND_BITS-1:0] KIND_PLUS    = 5'd11;
   localparam logic [KIND_BITS-1:0] KIND_MINUS   = 5'd12;
   localparam logic [KIND_BITS-1:0] KIND_STAR    = 5'd13;
   localparam logic [KIND_BITS-1:0] KIND_LESS    = 5'd14;
   localparam logic [KIND_BITS-1:0] KIND_GREATER = 5'd15;
   localparam logic [KIND_BITS-1:0] KIND_EQUAL   = 5'd16;
   localparam logic [KIND_BITS-1:0] KIND_NEWLINE = 5'd17;
   localparam logic [KIND_BITS-1:0] KIND_IDENT   = 5'd18;
   localparam logic [KIND_BITS-1:0] KIND_NUMBER  = 5'd19;
   localparam logic [KIND_BITS-1:0] KIND_NONE    = 5'd0;

   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_BITS-1:0] CHAR_DOT     = 8'h2E;
   localparam logic [CHAR_BITS-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_BITS-1:0] CHAR_TAB     = 8'h09;

   // Keywords with the first letter in the most significant used byte.
   localparam logic [LETTERS_BITS-1:0] KEYWORD_CODE [KEYWORD_COUNT] = '{
      48'h0000_0073_6574,  // set
      48'h0000_0000_6966,  // if
      48'h0000_656C_7365,  // else
      48'h0000_0000_646F,  // do
      48'h0075_6E74_696C,  // until
      48'h0000_0064_6566,  // def
      48'h7265_7475_726E   // return
   };

   // One result item; the first field sits in the highest bits.
   typedef struct packed {
      logic                  pad;
      logic [FAULT_BITS-1:0] fault;
      logic [LENGTH_BITS-1:0] length;
      logic [POSITION_BITS-1:0] start;
      logic [KIND_BITS-1:0]  kind;
   } rsp_item_type;

   typedef struct packed {
      logic                 hit;
      logic [KIND_BITS-1:0] kind;
   } single_kind_type;

   function automatic logic [KIND_BITS-1:0] keyword_kind(
      input logic [LETTERS_BITS-1:0] letters,
      input logic                    too_long
   );
      logic [KIND_BITS-1:0] kind;
      kind = KIND_IDENT;
      for (int i = 0; i < KEYWORD_COUNT; i++) begin
         if (letters == KEYWORD_CODE[i]) begin
            kind = i[KIND_BITS-1:0];
         end
      end
      if (too_long) begin
         kind = KIND_IDENT;
      end
      return kind;
   endfunction

   function automatic single_kind_type single_kind(input logic [CHAR_BITS-1:0] c);
      single_kind_type r;
      r.hit = 1'b1;
      unique case (c)
         8'h7B:   r.kind = KIND_LBRACE;
         8'h7D:   r.kind = KIND_RBRACE;
         8'h28:   r.kind = KIND_LPAREN;
         8'h29:   r.kind = KIND_RPAREN;
         8'h2B:   r.kind = KIND_PLUS;
         8'h2D:   r.kind = KIND_MINUS;
         8'h2A:   r.kind = KIND_STAR;
         8'h3C:   r.kind = KIND_LESS;
         8'h3E:   r.kind = KIND_GREATER;
         8'h3D:   r.kind = KIND_EQUAL;
         8'h0A:   r.kind = KIND_NEWLINE;
         default: begin
            r.hit  = 1'b0;
            r.kind = KIND_NONE;
         end
      endcase
      return r;
   endfunction

endpackage

// File: rtl/keyword_token_lexer_unit.sv
// Keyword token lexer: one source byte in per item, tokens out.
// Depends on ktl_pkg (types, keyword table, character decode).
//
// Usage:
//   The req_ channel carries one source byte per item in req_tdata[7:0]; req_tlast
//   set marks the end of the input, which flushes any pending word or number and
//   returns the scanner to idle with position zero (the byte is then ignored).
//   The rsp_ channel carries tokens: kind, start position, length and a fault
//   code in rsp_tdata, and rsp_tlast on the final token caused by one input item.
//   A fault (invalid byte, or '.' after a number) is reported once, after which
//   bytes are dropped until the end marker.
// Flow and throughput:
//   An accepted byte is held in the input register and decoded combinationally against
//   the scanner state while it is held; when it advances, its tokens are written to a
//   four-entry result queue, and the first token is presented from the queue register.
//   One byte is accepted every cycle while at least two queue entries are free; a byte
//   that ends a run and emits its own token produces two tokens, and the queue drains
//   one token per cycle, which sets the rate then.
// Reset and stall:
//   Reset empties the input register and the result queue and clears the scanner.
//   When the receiver stalls, the queue fills and req_tready drops once fewer than
//   two free entries remain; no token is lost or repeated.

module keyword_token_lexer_unit
   import ktl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // end_marker
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [4:0] token_kind, [20:5] token_start,
                                    // [28:21] token_length, [30:29] fault, [31] zero
   output logic        rsp_tlast    // last_of_run
);

   // Input register
   logic                 in_valid_ff, in_valid_in;
   logic [CHAR_BITS-1:0] in_char_ff;
   logic                 in_end_ff;

   // Scanner state
   scan_mode_type            mode_ff, mode_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] run_start_ff, run_start_in;
   logic [LENGTH_BITS-1:0]   run_len_ff, run_len_in;
   logic [LETTERS_BITS-1:0]  letters_ff, letters_in;
   logic                     too_long_ff, too_long_in;

   // Result queue
   rsp_item_type             q_data_ff [FIFO_DEPTH];
   logic                     q_last_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;

   logic            advance, pop;
   logic            is_letter, is_digit, is_dot, is_blank;
   logic            extend_word, extend_num, frac_fault, flush_hit, fresh;
   single_kind_type single;
   logic            res0_valid, res1_valid, res0_last;
   rsp_item_type    res0, res1, flush_item, own_item;
   logic            own_valid;
   logic            push0, push1;

   // Advance when at least two queue entries are free.
   assign advance    = in_valid_ff && (count_ff <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
   assign req_tready = !in_valid_ff || advance;
   assign pop        = rsp_tvalid && rsp_tready;

   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   assign is_letter = (in_char_ff >= CHAR_LOWER_A) && (in_char_ff <= CHAR_LOWER_Z);
   assign is_digit  = (in_char_ff >= CHAR_ZERO) && (in_char_ff <= CHAR_NINE);
   assign is_dot    = (in_char_ff == CHAR_DOT);
   assign is_blank  = (in_char_ff == CHAR_SPACE) || (in_char_ff == CHAR_TAB);
   assign single    = single_kind(in_char_ff);

   assign extend_word = !in_end_ff && (mode_ff == MODE_WORD) && is_letter;
   assign extend_num  = !in_end_ff && (mode_ff == MODE_NUMBER) && is_digit;
   assign frac_fault  = !in_end_ff && (mode_ff == MODE_NUMBER) && is_dot;
   // The byte is handled on its own after any pending run has been closed.
   assign fresh       = !in_end_ff && (mode_ff != MODE_ERROR) &&
                        !extend_word && !extend_num && !frac_fault;
   assign flush_hit   = ((mode_ff == MODE_WORD) || (mode_ff == MODE_NUMBER)) &&
                        (in_end_ff || fresh);

   // Next scanner state
   always_comb begin
      mode_in      = mode_ff;
      pos_in       = pos_ff;
      run_start_in = run_start_ff;
      run_len_in   = run_len_ff;
      letters_in   = letters_ff;
      too_long_in  = too_long_ff;
      if (advance) begin
         priority if (in_end_ff) begin
            mode_in      = MODE_IDLE;
            pos_in       = '0;
            run_start_in = '0;
            run_len_in   = '0;
            letters_in   = '0;
            too_long_in  = 1'b0;
         end else if (mode_ff == MODE_ERROR) begin
            mode_in = MODE_ERROR;
         end else if (frac_fault) begin
            mode_in = MODE_ERROR;
         end else begin
            pos_in = pos_ff + 1'b1;
            if (extend_word || extend_num) begin
               if (run_len_ff != '1) begin
                  run_len_in = run_len_ff + 1'b1;
               end
            end
            if (extend_word) begin
               letters_in = {letters_ff[LETTERS_BITS-CHAR_BITS-1:0], in_char_ff};
               if (run_len_in > LENGTH_BITS'(WORD_CHARS)) begin
                  too_long_in = 1'b1;
               end
            end
            if (fresh) begin
               if (is_letter || is_digit) begin
                  mode_in      = is_letter ? MODE_WORD : MODE_NUMBER;
                  run_start_in = pos_ff;
                  run_len_in   = LENGTH_BITS'(1);
                  letters_in   = is_letter ? LETTERS_BITS'(in_char_ff) : '0;
                  too_long_in  = 1'b0;
               end else if (single.hit || is_blank) begin
                  mode_in = MODE_IDLE;
               end else begin
                  mode_in = MODE_ERROR;
                  pos_in  = pos_ff;
               end
            end
         end
      end
   end

   // Result items for the byte in the input register
   always_comb begin
      flush_item.pad    = 1'b0;
      flush_item.fault  = FAULT_NONE;
      flush_item.length = run_len_ff;
      flush_item.start  = run_start_ff;
      flush_item.kind   = (mode_ff == MODE_WORD) ? keyword_kind(letters_ff, too_long_ff)
                                                 : KIND_NUMBER;

      own_item.pad   = 1'b0;
      own_item.start = pos_ff;
      own_valid      = 1'b0;
      if (frac_fault) begin
         own_valid       = 1'b1;
         own_item.fault  = FAULT_FRACTIONAL;
         own_item.length = '0;
         own_item.kind   = KIND_NONE;
      end else if (fresh && single.hit) begin
         own_valid       = 1'b1;
         own_item.fault  = FAULT_NONE;
         own_item.length = LENGTH_BITS'(1);
         own_item.kind   = single.kind;
      end else begin
         own_valid       = fresh && !is_letter && !is_digit && !is_blank;
         own_item.fault  = FAULT_INVALID;
         own_item.length = '0;
         own_item.kind   = KIND_NONE;
      end

      if (flush_hit) begin
         res0_valid = 1'b1;
         res0       = flush_item;
         res1_valid = own_valid;
      end else begin
         res0_valid = own_valid;
         res0       = own_item;
         res1_valid = 1'b0;
      end
      res1      = own_item;
      res0_last = !res1_valid;
   end

   assign push0 = advance && res0_valid;
   assign push1 = advance && res1_valid;

   // Queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_BITS'(push0) + FIFO_PTR_BITS'(push1);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_BITS'(pop);
      count_in  = count_ff + FIFO_CNT_BITS'(push0) + FIFO_CNT_BITS'(push1)
                  - FIFO_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mode_ff      <= MODE_IDLE;
         pos_ff       <= '0;
         run_start_ff <= '0;
         run_len_ff   <= '0;
         letters_ff   <= '0;
         too_long_ff  <= 1'b0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         mode_ff      <= mode_in;
         pos_ff       <= pos_in;
         run_start_ff <= run_start_in;
         run_len_ff   <= run_len_in;
         letters_ff   <= letters_in;
         too_long_ff  <= too_long_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
      if (push0) begin
         q_data_ff[wr_ptr_ff] <= res0;
         q_last_ff[wr_ptr_ff] <= res0_last;
      end
      if (push1) begin
         q_data_ff[wr_ptr_ff + 1'b1] <= res1;
         q_last_ff[wr_ptr_ff + 1'b1] <= 1'b1;
      end
   end

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = q_data_ff[rd_ptr_ff];
   assign rsp_tlast  = q_last_ff[rd_ptr_ff];

`ifndef ASSERT_OFF
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_BITS'(FIFO_DEPTH))
      else $error("result queue count exceeds its depth");

   a_two_needs_flush: assert property (@(posedge clock) disable iff (reset)
      push1 |-> (push0 && ((mode_ff == MODE_WORD) || (mode_ff == MODE_NUMBER))))
      else $error("second token without a pending run");

   a_error_sticks: assert property (@(posedge clock) disable iff (reset)
      (advance && !in_end_ff && (mode_ff == MODE_ERROR)) |=>
         ((mode_ff == MODE_ERROR) && $stable(pos_ff)))
      else $error("error mode left without end marker");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && in_end_ff) |=> ((mode_ff == MODE_IDLE) && (pos_ff == '0)))
      else $error("end marker did not return scanner to idle");
`endif

endmodule
